// File: src/snx3_pkg.sv
// Shared constants, types and small lookup functions for the 3D simplex noise block.
// Used by simplex_noise_3d; depends on nothing else.
package snx3_pkg;

  // Defaults for the top-level parameters
  localparam int PERM_ENTRIES_DEF = 512;
  localparam int COORD_FRAC_DEF   = 16;

  // Fixed field widths
  localparam int COORD_W    = 32;
  localparam int INDEX_W    = 9;
  localparam int VALUE_W    = 8;
  localparam int NOISE_W    = 16;
  localparam int IN_TDATA_W = 120;  // 113 payload bits, padded to whole bytes

  // Internal fixed-point working widths
  localparam int WORK_FRAC = 24;    // corner offsets in Q.24
  localparam int QUOT_W    = 27;    // offset quotient before removing its bias
  localparam int Q_W       = 26;    // corner offset, signed Q.24
  localparam int SQ_W      = 51;    // square of a corner offset
  localparam int T_W       = 24;    // t in Q.24
  localparam int T4_W      = 21;    // t^4 in Q.24, at most 2^20
  localparam int DOT_W     = 27;    // gradient dot product
  localparam int TERM_W    = 48;    // t^4 * dot, Q.48
  localparam int ACC_W     = 50;    // sum of four corner terms

  // Skew sum bias (3 * 2^31) so the divide by three runs on a nonnegative value
  localparam logic [33:0] SKEW_OFF = 34'd6442450944;
  // ceil(2^20 / 3): exact floor divide by three for 18-bit values, shift 20
  localparam logic [18:0] DIV3_M18 = 19'd349526;
  // Divide-by-six bias (3 * 2^26), quotient bias 2^25
  localparam logic [29:0] DIV6_OFF = 30'd201326592;
  localparam logic [QUOT_W-1:0] QUOT_BIAS = 27'd33554432;
  // ceil(2^30 / 3): exact floor divide by three for 28-bit values, shift 30
  localparam logic [28:0] DIV3_M28 = 29'd357913942;

  typedef logic signed [Q_W-1:0]   q_t;
  typedef logic signed [DOT_W-1:0] dot_t;
  typedef logic [3:0]              grad_t;

  // Gradient codes of the edge vectors, one per cube edge
  localparam grad_t G_PPZ = 4'd0;
  localparam grad_t G_NPZ = 4'd1;
  localparam grad_t G_PNZ = 4'd2;
  localparam grad_t G_NNZ = 4'd3;
  localparam grad_t G_PZP = 4'd4;
  localparam grad_t G_NZP = 4'd5;
  localparam grad_t G_PZN = 4'd6;
  localparam grad_t G_NZN = 4'd7;
  localparam grad_t G_ZPP = 4'd8;
  localparam grad_t G_ZNP = 4'd9;
  localparam grad_t G_ZPN = 4'd10;
  localparam grad_t G_ZNN = 4'd11;

  // Hash byte mod 12: quotient by reciprocal 171/2048, exact for 8-bit values
  function automatic grad_t hash_mod12(input logic [7:0] h);
    logic [15:0] p;
    logic [7:0]  rem;
    p   = 16'(h) * 16'd171;
    rem = h - 8'(p[15:11]) * 8'd12;
    return grad_t'(rem[3:0]);
  endfunction

  // Dot product of a gradient with the corner offset
  function automatic dot_t grad_dot(input grad_t g, input q_t q0, input q_t q1, input q_t q2);
    dot_t a;
    dot_t b;
    dot_t c;
    dot_t d;
    a = DOT_W'(q0);
    b = DOT_W'(q1);
    c = DOT_W'(q2);
    case (g)
      G_PPZ:   d = a + b;
      G_NPZ:   d = b - a;
      G_PNZ:   d = a - b;
      G_NNZ:   d = -a - b;
      G_PZP:   d = a + c;
      G_NZP:   d = c - a;
      G_PZN:   d = a - c;
      G_NZN:   d = -a - c;
      G_ZPP:   d = b + c;
      G_ZNP:   d = c - b;
      G_ZPN:   d = b - c;
      G_ZNN:   d = -b - c;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

// File: src/snx3_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Standalone; instanced by simplex_noise_3d for the permutation copies.
module snx3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write has priority; a read updates rdata only when enabled
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (en) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: src/simplex_noise_3d.sv
// 3D simplex noise evaluator, top level.
// Depends on snx3_pkg (constants, gradient functions) and snx3_ram (permutation copies).

// The block takes one word per clock and returns one noise word per evaluate word;
// permutation write words return nothing. The pipeline runs as a single unit: it
// moves whenever the output register is empty or being read, so throughput is one
// word per cycle while the output side keeps up. Each corner hash is three chained
// reads of the permutation table, so the table is held as twelve identical RAM
// copies (four corners times three lookup levels), each read once per word. A
// permutation write travels down the pipeline with the other words and lands in
// each copy at the stage where that copy is read, so every evaluate sees exactly
// the writes taken before it. No clearing pass is run after reset; entries must
// be written before they are used.
module simplex_noise_3d #(
  parameter int PERM_ENTRIES    = snx3_pkg::PERM_ENTRIES_DEF,
  parameter int COORD_FRAC_BITS = snx3_pkg::COORD_FRAC_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // coord_x[31:0], coord_y[63:32], coord_z[95:64], table_index[104:96],
  // table_value[112:105], zero pad above
  input  logic [snx3_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // op: 0 = permutation write, 1 = evaluate
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // noise_value[15:0]
  output logic [snx3_pkg::NOISE_W-1:0]    m_axis_tdata
);

  localparam int AW  = $clog2(PERM_ENTRIES);
  localparam int F   = COORD_FRAC_BITS;
  localparam int NW  = F + 4;
  localparam int NPW = F + 5;
  localparam int WSH = snx3_pkg::WORK_FRAC - F;
  localparam int VW  = snx3_pkg::VALUE_W;
  localparam int CW  = snx3_pkg::COORD_W;
  localparam logic signed [NPW-1:0] SIX_ONE = NPW'(6 * (1 << F));

  // Pipeline advance: output register empty or being taken
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Per-stage valid and evaluate flags
  logic [10:0] vld;
  logic [10:0] evl;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      evl <= '0;
    end else if (adv) begin
      vld <= {vld[9:0], s_axis_tvalid};
      evl <= {evl[9:0], s_axis_tvalid && s_axis_tuser};
    end
  end

  // ---------------- stage 0: input register ----------------
  logic signed [CW-1:0] pos0 [3];
  logic [AW-1:0]        idx0, idx1, idx2, idx3, idx4, idx5;
  logic [VW-1:0]        val0, val1, val2, val3, val4, val5;

  always_ff @(posedge clk) begin
    if (adv) begin
      pos0[0] <= s_axis_tdata[31:0];
      pos0[1] <= s_axis_tdata[63:32];
      pos0[2] <= s_axis_tdata[95:64];
      idx0    <= s_axis_tdata[96 +: AW];
      val0    <= s_axis_tdata[105 +: VW];
    end
  end

  // ---------------- stage 0 -> 1: skew sum, high half of divide by three ----------------
  logic [33:0] skew_u;
  logic [17:0] skew_hi;
  logic [36:0] prod_hi;
  logic [15:0] qh_next;
  logic [17:0] rh_full;

  always_comb begin
    skew_u  = 34'(pos0[0]) + 34'(pos0[1]) + 34'(pos0[2]) + snx3_pkg::SKEW_OFF;
    skew_hi = skew_u[33:16];
    prod_hi = 37'(skew_hi) * 37'(snx3_pkg::DIV3_M18);
    qh_next = prod_hi[35:20];
    rh_full = skew_hi - 18'({qh_next, 1'b0}) - 18'(qh_next);
  end

  logic [15:0]          qh1;
  logic [1:0]           rh1;
  logic [15:0]          ul1;
  logic signed [CW-1:0] pos1 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      qh1  <= qh_next;
      rh1  <= rh_full[1:0];
      ul1  <= skew_u[15:0];
      pos1 <= pos0;
      idx1 <= idx0;
      val1 <= val0;
    end
  end

  // ---------------- stage 1 -> 2: low half of divide, skew s and remainder ----------------
  logic [17:0] lo_v;
  logic [36:0] prod_lo;
  logic [15:0] qv;
  logic [17:0] rv_full;
  logic [31:0] skew_q;

  always_comb begin
    lo_v    = {rh1, ul1};
    prod_lo = 37'(lo_v) * 37'(snx3_pkg::DIV3_M18);
    qv      = prod_lo[35:20];
    rv_full = lo_v - 18'({qv, 1'b0}) - 18'(qv);
    skew_q  = {qh1, 16'b0} + 32'(qv);
  end

  logic signed [CW-1:0] s2;
  logic [1:0]           r2;
  logic signed [CW-1:0] pos2 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      s2   <= {~skew_q[31], skew_q[30:0]};
      r2   <= rv_full[1:0];
      pos2 <= pos1;
      idx2 <= idx1;
      val2 <= val1;
    end
  end

  // ---------------- stage 2 -> 3: cell, in-cell offsets, simplex choice ----------------
  logic [CW-1:0]        ps   [3];
  logic [F-1:0]         frac [3];
  logic [NW-1:0]        num_u [3];
  logic signed [NW-1:0] num_n [3];
  logic [2:0]           c1_next, c2_next;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ps[a]   = pos2[a] + s2;
      frac[a] = ps[a][F-1:0];
    end
    for (int a = 0; a < 3; a++) begin
      num_u[a] = NW'(frac[a]) * NW'(6) - NW'(frac[0]) - NW'(frac[1]) - NW'(frac[2])
                 + NW'(r2);
      num_n[a] = $signed(num_u[a]);
    end
    // corner codes are {z, y, x}
    c1_next = 3'b010;
    c2_next = 3'b011;
    if (num_n[0] >= num_n[1]) begin
      if (num_n[1] >= num_n[2]) begin
        c1_next = 3'b001;
        c2_next = 3'b011;
      end else if (num_n[0] >= num_n[2]) begin
        c1_next = 3'b001;
        c2_next = 3'b101;
      end else begin
        c1_next = 3'b100;
        c2_next = 3'b101;
      end
    end else begin
      if (num_n[1] < num_n[2]) begin
        c1_next = 3'b100;
        c2_next = 3'b110;
      end else if (num_n[0] < num_n[2]) begin
        c1_next = 3'b010;
        c2_next = 3'b110;
      end
    end
  end

  logic signed [NW-1:0] num3 [3];
  logic [7:0]           cm3 [3];
  logic [7:0]           cm4 [2];
  logic [7:0]           cm5;
  logic [2:0]           crn3 [4];
  logic [2:0]           crn4 [4];
  logic [2:0]           crn5 [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        num3[a] <= num_n[a];
        cm3[a]  <= ps[a][F +: 8];
      end
      crn3[0] <= 3'b000;
      crn3[1] <= c1_next;
      crn3[2] <= c2_next;
      crn3[3] <= 3'b111;
      idx3    <= idx2;
      val3    <= val2;
    end
  end

  // ---------------- permutation copies: [level][corner] ----------------
  logic [AW-1:0] rd_addr [3][4];
  logic [VW-1:0] rd_data [3][4];
  logic          wr_en   [3];
  logic [AW-1:0] wr_idx  [3];
  logic [VW-1:0] wr_val  [3];

  // A write lands in each level as it passes that level's read stage
  assign wr_en[0]  = adv && vld[3] && !evl[3];
  assign wr_en[1]  = adv && vld[4] && !evl[4];
  assign wr_en[2]  = adv && vld[5] && !evl[5];
  assign wr_idx[0] = idx3;
  assign wr_idx[1] = idx4;
  assign wr_idx[2] = idx5;
  assign wr_val[0] = val3;
  assign wr_val[1] = val4;
  assign wr_val[2] = val5;

  for (genvar lv = 0; lv < 3; lv++) begin : g_level
    for (genvar k = 0; k < 4; k++) begin : g_corner
      snx3_ram #(
        .WIDTH (VW),
        .DEPTH (PERM_ENTRIES)
      ) u_perm (
        .clk   (clk),
        .en    (adv),
        .we    (wr_en[lv]),
        .addr  (wr_en[lv] ? wr_idx[lv] : rd_addr[lv][k]),
        .wdata (wr_val[lv]),
        .rdata (rd_data[lv][k])
      );
    end
  end

  // Lookup addresses: z at stage 3, y at stage 4, x at stage 5
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rd_addr[0][k] = AW'(cm3[2]) + AW'(crn3[k][2]);
      rd_addr[1][k] = AW'(cm4[1]) + AW'(crn4[k][1]) + AW'(rd_data[0][k]);
      rd_addr[2][k] = AW'(cm5) + AW'(crn5[k][0]) + AW'(rd_data[1][k]);
    end
  end

  // ---------------- stage 3 -> 4: z lookup, corner offsets divided by six ----------------
  logic signed [NPW-1:0] np_v [4][3];
  logic signed [29:0]    w_v  [4][3];
  logic [29:0]           u6_v [4][3];
  logic [57:0]           p6_v [4][3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int a = 0; a < 3; a++) begin
        np_v[k][a] = NPW'(num3[a]) - (crn3[k][a] ? SIX_ONE : '0) + NPW'(k * (1 << F));
        w_v[k][a]  = 30'(np_v[k][a]) <<< WSH;
        u6_v[k][a] = w_v[k][a] + snx3_pkg::DIV6_OFF;
        p6_v[k][a] = 58'(u6_v[k][a][28:1]) * 58'(snx3_pkg::DIV3_M28);
      end
    end
  end

  logic [snx3_pkg::QUOT_W-1:0] quot4 [4][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        for (int a = 0; a < 3; a++) begin
          quot4[k][a] <= p6_v[k][a][56:30];
        end
      end
      cm4[0] <= cm3[0];
      cm4[1] <= cm3[1];
      crn4   <= crn3;
      idx4   <= idx3;
      val4   <= val3;
    end
  end

  // ---------------- stage 4 -> 5: y lookup, remove quotient bias ----------------
  snx3_pkg::q_t q5 [4][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        for (int a = 0; a < 3; a++) begin
          q5[k][a] <= snx3_pkg::Q_W'(quot4[k][a] - snx3_pkg::QUOT_BIAS);
        end
      end
      cm5  <= cm4[0];
      crn5 <= crn4;
      idx5 <= idx4;
      val5 <= val4;
    end
  end

  // ---------------- stage 5 -> 6: x lookup, squares ----------------
  logic signed [51:0]        sqf [4][3];
  logic [snx3_pkg::SQ_W-1:0] sq6 [4][3];
  snx3_pkg::q_t              q6  [4][3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int a = 0; a < 3; a++) begin
        sqf[k][a] = 52'(q5[k][a]) * 52'(q5[k][a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        for (int a = 0; a < 3; a++) begin
          sq6[k][a] <= sqf[k][a][snx3_pkg::SQ_W-1:0];
        end
      end
      q6 <= q5;
    end
  end

  // ---------------- stage 6 -> 7: t = 0.5 - |d|^2, gradient pick ----------------
  logic [53:0] t48 [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      t48[k] = (54'(1) << 47) - 54'(sq6[k][0]) - 54'(sq6[k][1]) - 54'(sq6[k][2]);
    end
  end

  logic [snx3_pkg::T_W-1:0] t24_7 [4];
  logic                     tpos7 [4];
  snx3_pkg::grad_t          g7    [4];
  snx3_pkg::q_t             q7    [4][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        t24_7[k] <= t48[k][47:24];
        tpos7[k] <= !t48[k][53] && (t48[k] != '0);
        g7[k]    <= snx3_pkg::hash_mod12(rd_data[2][k]);
      end
      q7 <= q6;
    end
  end

  // ---------------- stage 7 -> 8: t^2, dot ----------------
  logic [47:0] t2f [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      t2f[k] = 48'(t24_7[k]) * 48'(t24_7[k]);
    end
  end

  logic [snx3_pkg::T_W-1:0] t2_8  [4];
  logic                     tpos8 [4];
  snx3_pkg::dot_t           dot8  [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        t2_8[k]  <= t2f[k][47:24];
        tpos8[k] <= tpos7[k];
        dot8[k]  <= snx3_pkg::grad_dot(g7[k], q7[k][0], q7[k][1], q7[k][2]);
      end
    end
  end

  // ---------------- stage 8 -> 9: t^4 ----------------
  logic [47:0] t4f [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      t4f[k] = 48'(t2_8[k]) * 48'(t2_8[k]);
    end
  end

  logic [snx3_pkg::T4_W-1:0] t4_9  [4];
  logic                      tpos9 [4];
  snx3_pkg::dot_t            dot9  [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        t4_9[k]  <= t4f[k][44:24];
        tpos9[k] <= tpos8[k];
      end
      dot9 <= dot8;
    end
  end

  // ---------------- stage 9 -> 10: corner contribution ----------------
  logic signed [snx3_pkg::TERM_W-1:0] term_v  [4];
  logic signed [snx3_pkg::TERM_W-1:0] term10 [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      term_v[k] = $signed({1'b0, t4_9[k]}) * dot9[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        term10[k] <= tpos9[k] ? term_v[k] : '0;
      end
    end
  end

  // ---------------- stage 10 -> out: sum, scale by 32, round, saturate ----------------
  logic signed [snx3_pkg::ACC_W-1:0] acc;
  logic signed [snx3_pkg::ACC_W-1:0] racc;
  logic signed [21:0]                scaled;
  logic [snx3_pkg::NOISE_W-1:0]      noise_next;

  always_comb begin
    acc    = snx3_pkg::ACC_W'(term10[0]) + snx3_pkg::ACC_W'(term10[1])
           + snx3_pkg::ACC_W'(term10[2]) + snx3_pkg::ACC_W'(term10[3]);
    racc   = acc + (snx3_pkg::ACC_W'(1) <<< 27);
    scaled = 22'(racc >>> 28);
    if (scaled > 22'sd32767) begin
      noise_next = 16'h7fff;
    end else if (scaled < -22'sd32768) begin
      noise_next = 16'h8000;
    end else begin
      noise_next = scaled[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= vld[10] && evl[10];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= noise_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A stalled pipeline keeps its words in place
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld) && $stable(evl))
    else $error("pipeline moved while stalled");

  // Every evaluate word leaving the last stage shows up at the output
  a_eval_out: assert property (@(posedge clk) disable iff (rst)
    adv && vld[10] && evl[10] |=> m_axis_tvalid)
    else $error("evaluate word lost at output");

  // A write word never produces an output word
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    adv && vld[10] && !evl[10] |=> !m_axis_tvalid)
    else $error("write word produced output");

  // Positive t of corner 0 stays at most one half
  a_t_bound: assert property (@(posedge clk) disable iff (rst)
    vld[7] && evl[7] && tpos7[0] |-> t24_7[0] <= 24'h800000)
    else $error("falloff t out of range");
`endif

endmodule
